// ===== rtl/core/kvt_pkg.sv =====
`default_nettype none

package kvt_pkg;

	// Operation codes carried by the func field.
	typedef enum logic [1:0] {
		FN_PUT = 2'd0,
		FN_GET = 2'd1,
		FN_DEL = 2'd2
	} func_t;

	// Result codes carried by the status field.
	typedef enum logic [1:0] {
		ST_DONE = 2'd0,
		ST_HIT  = 2'd1,
		ST_MISS = 2'd2,
		ST_FULL = 2'd3
	} status_t;

	typedef struct packed {
		status_t status;
		logic    hit;
	} kvt_res_t;

	typedef struct packed {
		logic key_we;
		logic value_we;
	} kvt_ram_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/kvt_ram.sv =====
`default_nettype none

module kvt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] addr,
	input  wire logic [WIDTH-1:0]  wdata,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

`default_nettype wire

// ===== rtl/core/kvt_seq.sv =====
`default_nettype none

module kvt_seq
	import kvt_pkg::*;
#(
	parameter int ENTRIES = 8,
	parameter int KEY_BITS = 32,
	parameter int VALUE_BITS = 32,
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [1:0]            func,
	input  wire logic [KEY_BITS-1:0]   key,
	input  wire logic [VALUE_BITS-1:0] value,
	output logic [IDX_W-1:0]           ram_addr,
	output kvt_ram_ctl_t               ram_ctl,
	output logic [KEY_BITS-1:0]        key_wdata,
	output logic [VALUE_BITS-1:0]      value_wdata,
	input  wire logic [KEY_BITS-1:0]   key_rdata,
	input  wire logic [VALUE_BITS-1:0] value_rdata,
	input  wire logic                  res_ready,
	output logic                       res_valid,
	output kvt_res_t                   res,
	output logic [VALUE_BITS-1:0]      res_value
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH
	} state_t;

	localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

	state_t                 state_q;
	logic [ENTRIES-1:0]     valid_q;
	logic [IDX_W-1:0]       idx_q;
	logic                   issue_done_q;
	logic                   cmp_s1;
	logic [IDX_W-1:0]       cidx_s1;
	logic                   found_q;
	logic                   free_hit_q;
	logic [IDX_W-1:0]       slot_q;
	logic [IDX_W-1:0]       free_slot_q;
	logic [1:0]             func_q;
	logic [KEY_BITS-1:0]    key_q;
	logic [VALUE_BITS-1:0]  value_q;
	logic [VALUE_BITS-1:0]  found_value_q;
	logic                   match;
	logic                   del_hit;
	logic                   finish;

	assign in_stall = (state_q != S_IDLE);
	assign finish   = (state_q == S_FINISH) && res_ready;
	assign res_valid = finish;

	// The single comparator looks at the entry whose read was issued last cycle.
	assign match = cmp_s1 && valid_q[cidx_s1] && (key_rdata == key_q);

	assign key_wdata   = key_q;
	assign value_wdata = value_q;

	always_comb begin
		res       = '{status: ST_MISS, hit: 1'b0};
		res_value = '0;
		ram_ctl   = '0;
		del_hit   = 1'b0;
		case (func_q)
			FN_PUT: begin
				if (found_q) begin
					res = '{status: ST_HIT, hit: 1'b1};
					ram_ctl.value_we = finish;
				end else if (free_hit_q) begin
					res = '{status: ST_DONE, hit: 1'b0};
					ram_ctl.key_we   = finish;
					ram_ctl.value_we = finish;
				end else begin
					res = '{status: ST_FULL, hit: 1'b0};
				end
			end
			FN_GET: begin
				if (found_q) begin
					res       = '{status: ST_HIT, hit: 1'b1};
					res_value = found_value_q;
				end
			end
			FN_DEL: begin
				if (found_q) begin
					res     = '{status: ST_DONE, hit: 1'b1};
					del_hit = finish;
				end
			end
			default: begin
				res = '{status: ST_MISS, hit: 1'b0};
			end
		endcase
	end

	always_comb begin
		if (state_q == S_FINISH) begin
			ram_addr = found_q ? slot_q : free_slot_q;
		end else begin
			ram_addr = idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			valid_q      <= '0;
			idx_q        <= '0;
			issue_done_q <= 1'b0;
			cmp_s1       <= 1'b0;
			found_q      <= 1'b0;
			free_hit_q   <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						idx_q        <= '0;
						issue_done_q <= 1'b0;
						cmp_s1       <= 1'b0;
						found_q      <= 1'b0;
						free_hit_q   <= 1'b0;
						state_q      <= S_SCAN;
					end
				end
				S_SCAN: begin
					cmp_s1 <= !issue_done_q;
					if (!issue_done_q) begin
						if (idx_q == LAST) begin
							issue_done_q <= 1'b1;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
					if (match) begin
						found_q <= 1'b1;
						state_q <= S_FINISH;
					end else if (cmp_s1) begin
						if (!valid_q[cidx_s1] && !free_hit_q) begin
							free_hit_q <= 1'b1;
						end
						if (cidx_s1 == LAST) begin
							state_q <= S_FINISH;
						end
					end
				end
				S_FINISH: begin
					if (finish) begin
						if (ram_ctl.key_we) begin
							valid_q[free_slot_q] <= 1'b1;
						end
						if (del_hit) begin
							valid_q[slot_q] <= 1'b0;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			func_q  <= func;
			key_q   <= key;
			value_q <= value;
		end
		cidx_s1 <= idx_q;
		if (state_q == S_SCAN) begin
			if (match) begin
				slot_q        <= cidx_s1;
				found_value_q <= value_rdata;
			end
			if (cmp_s1 && !valid_q[cidx_s1] && !free_hit_q) begin
				free_slot_q <= cidx_s1;
			end
		end
	end

`ifndef ASSERT_OFF
	a_insert_free: assert property (@(posedge clk) disable iff (!arst_n)
		ram_ctl.key_we |-> !valid_q[free_slot_q])
		else $error("insert targets an occupied slot");

	a_accept_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == S_SCAN) && !found_q && !free_hit_q)
		else $error("accepted item did not start a clean scan");

	a_scan_valid_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |=> $stable(valid_q))
		else $error("valid bits changed during a scan");

	a_full_means_full: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.status == ST_FULL) |-> (&valid_q))
		else $error("table full reported with a free slot");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/small_key_value_table_core.sv =====
// Channel   Direction  Handshake            Fields
// input     in         in_valid, in_stall   func, key, value
// output    out        out_valid, out_stall status, hit, value_out
//
// One item is accepted only while the sequencer is idle; the scan through the
// key RAM checks one entry per cycle with a single comparator and stops at the
// first match, or after the last entry when no key matches.
// Reset clears all valid bits at once; the key and value RAMs need no clearing.
// A result waits in the output register; a stalled output holds the finish step.

`default_nettype none

module small_key_value_table_core
	import kvt_pkg::*;
#(
	parameter int ENTRIES = 8,
	parameter int KEY_BITS = 32,
	parameter int VALUE_BITS = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [1:0]            func,
	input  wire logic [KEY_BITS-1:0]   key,
	input  wire logic [VALUE_BITS-1:0] value,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [1:0]                 status,
	output logic                       hit,
	output logic [VALUE_BITS-1:0]      value_out
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	logic [IDX_W-1:0]      ram_addr;
	kvt_ram_ctl_t          ram_ctl;
	logic [KEY_BITS-1:0]   key_wdata;
	logic [VALUE_BITS-1:0] value_wdata;
	logic [KEY_BITS-1:0]   key_rdata;
	logic [VALUE_BITS-1:0] value_rdata;
	logic                  res_ready;
	logic                  res_valid;
	kvt_res_t              res;
	logic [VALUE_BITS-1:0] res_value;
	logic                  out_valid_q;
	kvt_res_t              res_q;
	logic [VALUE_BITS-1:0] value_out_q;

	kvt_ram #(
		.WIDTH (KEY_BITS),
		.DEPTH (ENTRIES)
	) u_key_ram (
		.clk   (clk),
		.we    (ram_ctl.key_we),
		.addr  (ram_addr),
		.wdata (key_wdata),
		.rdata (key_rdata)
	);

	kvt_ram #(
		.WIDTH (VALUE_BITS),
		.DEPTH (ENTRIES)
	) u_value_ram (
		.clk   (clk),
		.we    (ram_ctl.value_we),
		.addr  (ram_addr),
		.wdata (value_wdata),
		.rdata (value_rdata)
	);

	kvt_seq #(
		.ENTRIES    (ENTRIES),
		.KEY_BITS   (KEY_BITS),
		.VALUE_BITS (VALUE_BITS)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.func        (func),
		.key         (key),
		.value       (value),
		.ram_addr    (ram_addr),
		.ram_ctl     (ram_ctl),
		.key_wdata   (key_wdata),
		.value_wdata (value_wdata),
		.key_rdata   (key_rdata),
		.value_rdata (value_rdata),
		.res_ready   (res_ready),
		.res_valid   (res_valid),
		.res         (res),
		.res_value   (res_value)
	);

	// The output register takes a new item when empty or when its item leaves.
	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			res_q       <= res;
			value_out_q <= res_value;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = res_q.status;
	assign hit       = res_q.hit;
	assign value_out = value_out_q;

endmodule

`default_nettype wire

// ===== tb/kvt_table_checker.sv =====
`default_nettype none

module kvt_table_checker
	import kvt_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic [1:0]  func,
	input  wire logic [31:0] key,
	input  wire logic [31:0] value,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [1:0]  status,
	input  wire logic        hit,
	input  wire logic [31:0] value_out,
	output int               fail_count,
	output int               pending
);

	localparam int SLOTS = 8;

	typedef struct {
		status_t     status;
		logic        hit;
		logic [31:0] value_out;
	} kvt_reply_t;

	// Shadow copy of the table contents.
	logic        shadow_valid [SLOTS];
	logic [31:0] shadow_key   [SLOTS];
	logic [31:0] shadow_value [SLOTS];

	kvt_reply_t expected_replies[$];
	kvt_reply_t want;
	int mismatches = 0;
	int outstanding = 0;

	assign fail_count = mismatches;
	assign pending = outstanding;

	// Applies one request to the shadow table and returns the reply it should produce.
	function automatic kvt_reply_t apply_request(input logic [1:0] op, input logic [31:0] k,
			input logic [31:0] v);
		kvt_reply_t r;
		int slot;
		int free_slot;
		r.status = ST_MISS;
		r.hit = 1'b0;
		r.value_out = '0;
		slot = -1;
		free_slot = -1;
		// Walking downward leaves the lowest match and the lowest free slot.
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (shadow_valid[i] && shadow_key[i] == k)
				slot = i;
			if (!shadow_valid[i])
				free_slot = i;
		end
		case (op)
			FN_PUT: begin
				if (slot >= 0) begin
					shadow_value[slot] = v;
					r.status = ST_HIT;
					r.hit = 1'b1;
				end else if (free_slot >= 0) begin
					shadow_valid[free_slot] = 1'b1;
					shadow_key[free_slot] = k;
					shadow_value[free_slot] = v;
					r.status = ST_DONE;
				end else begin
					r.status = ST_FULL;
				end
			end
			FN_GET: begin
				if (slot >= 0) begin
					r.status = ST_HIT;
					r.hit = 1'b1;
					r.value_out = shadow_value[slot];
				end
			end
			FN_DEL: begin
				if (slot >= 0) begin
					shadow_valid[slot] = 1'b0;
					r.status = ST_DONE;
					r.hit = 1'b1;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (shadow_valid[i])
				shadow_valid[i] = 1'b0;
			expected_replies.delete();
			outstanding = 0;
		end else begin
			// Results first: a result can never belong to the item taken at this edge.
			if (out_valid && !out_stall) begin
				if (expected_replies.size() == 0) begin
					$error("result item with no request waiting: status %0d hit %0d value_out %h",
						status, hit, value_out);
					mismatches++;
				end else begin
					want = expected_replies.pop_front();
					if (status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, status);
						mismatches++;
					end
					if (hit !== want.hit) begin
						$error("hit: expected %0d, actual %0d", want.hit, hit);
						mismatches++;
					end
					if (value_out !== want.value_out) begin
						$error("value_out: expected %h, actual %h", want.value_out, value_out);
						mismatches++;
					end
				end
			end
			if (in_valid && !in_stall)
				expected_replies.push_back(apply_request(func, key, value));
			outstanding = expected_replies.size();
		end
	end

endmodule

`default_nettype wire

// ===== tb/small_key_value_table_core_tb.sv =====
`default_nettype none

module small_key_value_table_core_tb;
	import kvt_pkg::*;

	localparam logic [1:0] FN_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 1800;
	localparam int HOLD_CYCLES = 300;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  func = '0;
	logic [31:0] key = '0;
	logic [31:0] value = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic        hit;
	logic [31:0] value_out;

	int fail_count;
	int pending;

	// quiet switches off random idling on both sides; hold_req asks for one long output stall.
	logic quiet = 1'b0;
	logic hold_req = 1'b0;

	small_key_value_table_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.key       (key),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.hit       (hit),
		.value_out (value_out)
	);

	kvt_table_checker table_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.key        (key),
		.value      (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.hit        (hit),
		.value_out  (value_out),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("TEST FAILED");
		$finish;
	end

	// Entered and left on a falling edge; returns once the item has been taken.
	task automatic send_request(input logic [1:0] op, input logic [31:0] k, input logic [31:0] v);
		while (!quiet && $urandom_range(99) < 9) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		func <= op;
		key <= k;
		value <= v;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
	endtask

	// Result side: random stalls, plus one long hold-off that lets the block back up.
	initial begin
		bit hold_done;
		hold_done = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				out_stall <= !quiet && ($urandom_range(99) < 9);
			end
		end
	end

	initial begin
		logic [31:0] key_pool [12];
		logic [1:0]  op;
		logic [31:0] k;
		logic [31:0] v;
		int          pick;
		int          phase;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part: empty table, extreme keys and values, update, fill, reuse.
		send_request(FN_GET, 32'h0000_0000, 32'h1234_5678);
		send_request(FN_DEL, 32'h0000_0000, 32'h0);
		send_request(FN_UNUSED, 32'h0000_0000, 32'hFFFF_FFFF);
		send_request(FN_PUT, 32'h0000_0000, 32'h0000_0000);
		send_request(FN_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(FN_GET, 32'h0000_0000, 32'h0);
		send_request(FN_GET, 32'hFFFF_FFFF, 32'h0);
		send_request(FN_PUT, 32'h0000_0000, 32'hA5A5_A5A5);
		send_request(FN_GET, 32'h0000_0000, 32'h0);
		for (int i = 1; i <= 6; i++)
			send_request(FN_PUT, i, 32'h0101_0101 * i);
		send_request(FN_PUT, 32'h7, 32'h7777_7777);
		send_request(FN_GET, 32'h7, 32'h0);
		send_request(FN_DEL, 32'h3, 32'h0);
		send_request(FN_PUT, 32'h7, 32'h5A5A_5A5A);
		send_request(FN_GET, 32'h7, 32'h0);
		send_request(FN_DEL, 32'hFFFF_FFFF, 32'h0);
		send_request(FN_DEL, 32'hFFFF_FFFF, 32'h0);
		send_request(FN_UNUSED, 32'h0000_0000, 32'h0);
		send_request(FN_GET, 32'h0000_0000, 32'h0);

		// A small key pool keeps hits, full tables and reuse of freed slots frequent.
		key_pool[0] = 32'h0000_0000;
		key_pool[1] = 32'hFFFF_FFFF;
		for (int i = 2; i < 12; i++)
			key_pool[i] = $urandom;

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 100)
				hold_req <= 1'b1;
			quiet <= (n >= 600 && n < 900);
			phase = (n / 150) % 3;
			pick = $urandom_range(99);
			case (phase)
				0: op = pick < 60 ? FN_PUT : pick < 85 ? FN_GET : pick < 97 ? FN_DEL : FN_UNUSED;
				1: op = pick < 25 ? FN_PUT : pick < 55 ? FN_GET : pick < 97 ? FN_DEL : FN_UNUSED;
				default: op = pick < 40 ? FN_PUT : pick < 70 ? FN_GET : pick < 97 ? FN_DEL : FN_UNUSED;
			endcase
			if ($urandom_range(99) < 85)
				k = key_pool[$urandom_range(11)];
			else
				k = $urandom;
			pick = $urandom_range(19);
			v = pick == 0 ? 32'h0 : pick == 1 ? 32'hFFFF_FFFF : $urandom;
			send_request(op, k, v);
		end
		in_valid <= 1'b0;

		wait (pending == 0);
		repeat (16) @(posedge clk);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/core/kvt_pkg.sv
rtl/core/kvt_ram.sv
rtl/core/kvt_seq.sv
rtl/core/small_key_value_table_core.sv
tb/kvt_table_checker.sv
tb/small_key_value_table_core_tb.sv
